### hw/rtl/plk_pkg.sv
// Shared types and constants of the plucked string synthesizer.
`timescale 1ns / 1ps

package plk_pkg;

    // Port field widths
    localparam int CMD_W      = 2;
    localparam int NOTE_W     = 16;
    localparam int NOISE_W    = 12;
    localparam int DAC_W      = 12;
    localparam int RATE_W     = 18;
    localparam int COEFF_W    = 12;
    localparam int TIMEOUT_W  = 20;
    localparam int ELAPSED_W  = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_COEFF_NEAR  = 2'd1,
        REG_COEFF_FAR   = 2'd2,
        REG_TIMEOUT     = 2'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [RATE_W-1:0]           SAMPLE_RATE_RST = 18'd100000;
    localparam logic signed [COEFF_W-1:0]   COEFF_NEAR_RST  = 12'sd500;
    localparam logic signed [COEFF_W-1:0]   COEFF_FAR_RST   = 12'sd500;
    localparam logic [TIMEOUT_W-1:0]        TIMEOUT_RST     = 20'd300000;

    // Gains are in thousandths
    localparam logic [NOTE_W-1:0]           GAIN_SCALE      = 16'd1000;

    // Elapsed tick counter saturates here
    localparam logic [ELAPSED_W-1:0]        ELAPSED_MAX     = 21'h1FFFFF;

endpackage

### hw/rtl/plucked_string_synth.sv
// Top level of the plucked string synthesizer: control, delay-line memory, tick datapath.
`timescale 1ns / 1ps

// Karplus-Strong plucked string voice around a ring delay line in block RAM.
// Input channel (s_valid/s_ready): one command per transaction.
//   start: order = sample_rate / note_freq, clamped to 2..MAX_ORDER (note 0
//          gives MAX_ORDER); rewinds ring index, load pointer, tick count; plays.
//   load:  writes one noise sample at the load pointer, pointer wraps at order+1.
//   tick:  while playing, mixes the two entries ahead of the ring index and
//          writes the saturated sum back; one result transaction on m_*.
// Load, start with note 0, idle or timed-out tick and stray codes are done in the
// idle state. A start with a nonzero note waits in the order step for the
// bit-serial divider, DIV_W (the sample rate width) bits wide. A playing tick
// makes two delay-line reads through the single read port, one gain multiply
// each, the two scalings by 1/1000 (reciprocal multiply on one shared multiplier),
// the mix, and the write-back. The result sits in an output register; a waiting
// result does not stop new commands, only a tick that finishes while the
// previous result is still untaken holds in its write-back step until m_ready
// frees the register. Reset (synchronous, aresetn low) stops playing, clears
// index, order, load pointer and tick count, and restores register defaults.
// The delay line is not cleared: every entry must be loaded before a tick reads it.
// Configuration writes (cfg_wr_en) take effect at once; they are to be made while
// idle, a rule for the user that the block itself does not enforce.

module plucked_string_synth
    import plk_pkg::*;
#(
    parameter int MAX_ORDER   = 511,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wr_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CMD_W-1:0]            s_cmd,
    input  logic [NOTE_W-1:0]           s_note_freq,
    input  logic signed [NOISE_W-1:0]   s_noise_sample,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [DAC_W-1:0]            m_dac_code
);

    localparam int DEPTH  = MAX_ORDER + 1;
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int PROD_W = COEFF_W + SAMPLE_BITS;
    localparam int MAG_W  = PROD_W - 1;
    localparam int DIV_W  = RATE_W;
    localparam int TERM_W = SAMPLE_BITS + 2;
    localparam int SUM_W  = TERM_W + 1;
    localparam int EXT_W  = ((SAMPLE_BITS > DAC_W) ? SAMPLE_BITS : DAC_W) + 1;

    // ceil(2^RCP_SH / 1000): the floor of mag * RCP_MUL >> RCP_SH is exact
    // for any magnitude below 2^MAG_W, since the rounding excess is under 2^10
    localparam int              RCP_SH  = MAG_W + 10;
    localparam int              RCP_W   = MAG_W + 1;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(GAIN_SCALE) - 64'd1) / 64'(GAIN_SCALE));

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - 1;
    localparam logic signed [EXT_W-1:0] EXT_MAX = EXT_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [EXT_W-1:0] EXT_MIN = -EXT_MAX - 1;
    localparam logic [EXT_W-1:0]        EXT_HALF = EXT_W'(1 << (SAMPLE_BITS - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORDER,
        ST_FAR_MUL,
        ST_NEAR_MUL,
        ST_FAR_SCALE,
        ST_NEAR_SCALE,
        ST_MIX,
        ST_WRITE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RATE_W-1:0]          sample_rate_reg;
    logic signed [COEFF_W-1:0]  coeff_near_reg;
    logic signed [COEFF_W-1:0]  coeff_far_reg;
    logic [TIMEOUT_W-1:0]       timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= SAMPLE_RATE_RST;
            coeff_near_reg  <= COEFF_NEAR_RST;
            coeff_far_reg   <= COEFF_FAR_RST;
            timeout_reg     <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_SAMPLE_RATE: sample_rate_reg <= cfg_wr_data[RATE_W-1:0];
                REG_COEFF_NEAR:  coeff_near_reg  <= $signed(cfg_wr_data[COEFF_W-1:0]);
                REG_COEFF_FAR:   coeff_far_reg   <= $signed(cfg_wr_data[COEFF_W-1:0]);
                REG_TIMEOUT:     timeout_reg     <= cfg_wr_data[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Delay line: one write port, one registered read port
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_rdata_reg;
    logic                          mem_we;
    logic [ORD_W-1:0]              mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;
    logic [ORD_W-1:0]              mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Divider for the order computation
    // ------------------------------------------------------------------
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [NOTE_W-1:0] div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quotient;

    plk_div #(
        .DVD_W (DIV_W),
        .DVS_W (NOTE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Control state and datapath registers
    // ------------------------------------------------------------------
    state_t                         state_reg, state_next;
    logic [ORD_W-1:0]               ring_index_reg, ring_index_next;
    logic [ORD_W-1:0]               ring_order_reg, ring_order_next;
    logic [ORD_W-1:0]               load_ptr_reg, load_ptr_next;
    logic                           playing_reg, playing_next;
    logic [ELAPSED_W-1:0]           elapsed_reg, elapsed_next;
    logic [ORD_W-1:0]               idx_near_reg, idx_near_next;
    logic signed [PROD_W-1:0]       prod_far_reg, prod_far_next;
    logic signed [PROD_W-1:0]       prod_near_reg, prod_near_next;
    logic signed [TERM_W-1:0]       term_far_reg, term_far_next;
    logic signed [TERM_W-1:0]       term_near_reg, term_near_next;
    logic signed [SAMPLE_BITS-1:0]  y_reg, y_next;
    logic                           m_valid_reg, m_valid_next;
    logic [DAC_W-1:0]               m_dac_reg, m_dac_next;

    // Ring neighbors of the index, wrapping at order+1 entries
    logic [ORD_W-1:0] idx_far;
    logic [ORD_W-1:0] idx_near;
    logic [ORD_W-1:0] load_ptr_adv;
    assign idx_far      = (ring_index_reg == ring_order_reg) ? '0 : ring_index_reg + 1'b1;
    assign idx_near     = (idx_far == ring_order_reg) ? '0 : idx_far + 1'b1;
    assign load_ptr_adv = (load_ptr_reg == ring_order_reg) ? '0 : load_ptr_reg + 1'b1;

    // Saturating tick count
    logic [ELAPSED_W-1:0] elapsed_inc;
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    // Noise clamped to the sample range
    logic signed [EXT_W-1:0]       noise_ext;
    logic signed [SAMPLE_BITS-1:0] noise_sat;
    assign noise_ext = {{(EXT_W-NOISE_W){s_noise_sample[NOISE_W-1]}}, s_noise_sample};
    always_comb begin
        if (noise_ext > EXT_MAX) begin
            noise_sat = EXT_MAX[SAMPLE_BITS-1:0];
        end else if (noise_ext < EXT_MIN) begin
            noise_sat = EXT_MIN[SAMPLE_BITS-1:0];
        end else begin
            noise_sat = noise_ext[SAMPLE_BITS-1:0];
        end
    end

    // Order from the divider quotient, clamped
    logic [ORD_W-1:0] order_clamped;
    always_comb begin
        if (div_quotient < DIV_W'(2)) begin
            order_clamped = ORD_W'(2);
        end else if (div_quotient > DIV_W'(MAX_ORDER)) begin
            order_clamped = ORD_W'(MAX_ORDER);
        end else begin
            order_clamped = div_quotient[ORD_W-1:0];
        end
    end

    // Product magnitudes; sign is reapplied after scaling
    logic [PROD_W-1:0] far_abs;
    logic [PROD_W-1:0] near_abs;
    assign far_abs  = prod_far_reg[PROD_W-1]  ? -prod_far_reg  : prod_far_reg;
    assign near_abs = prod_near_reg[PROD_W-1] ? -prod_near_reg : prod_near_reg;

    // Scale by 1/1000 with one multiplier shared by both terms;
    // truncation toward zero since the magnitude is scaled
    logic [MAG_W-1:0]         scale_mag;
    logic                     scale_neg;
    logic [MAG_W+RCP_W-1:0]   scale_prod;
    logic signed [TERM_W-1:0] scale_quo;
    logic signed [TERM_W-1:0] scale_term;
    always_comb begin
        if (state_reg == ST_NEAR_SCALE) begin
            scale_mag = near_abs[MAG_W-1:0];
            scale_neg = prod_near_reg[PROD_W-1];
        end else begin
            scale_mag = far_abs[MAG_W-1:0];
            scale_neg = prod_far_reg[PROD_W-1];
        end
    end
    assign scale_prod = scale_mag * RCP_MUL;
    assign scale_quo  = $signed({1'b0, scale_prod[RCP_SH +: TERM_W-1]});
    assign scale_term = scale_neg ? -scale_quo : scale_quo;

    // Mix and saturate
    logic signed [SUM_W-1:0]       mix_sum;
    logic signed [SAMPLE_BITS-1:0] mix_sat;
    assign mix_sum = SUM_W'(term_far_reg) + SUM_W'(term_near_reg);
    always_comb begin
        if (mix_sum > SUM_MAX) begin
            mix_sat = SUM_MAX[SAMPLE_BITS-1:0];
        end else if (mix_sum < SUM_MIN) begin
            mix_sat = SUM_MIN[SAMPLE_BITS-1:0];
        end else begin
            mix_sat = mix_sum[SAMPLE_BITS-1:0];
        end
    end

    // Offset-binary DAC code
    logic [EXT_W-1:0] dac_full;
    assign dac_full = {{(EXT_W-SAMPLE_BITS){y_reg[SAMPLE_BITS-1]}}, y_reg} + EXT_HALF;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        ring_index_next = ring_index_reg;
        ring_order_next = ring_order_reg;
        load_ptr_next   = load_ptr_reg;
        playing_next    = playing_reg;
        elapsed_next    = elapsed_reg;
        idx_near_next   = idx_near_reg;
        prod_far_next   = prod_far_reg;
        prod_near_next  = prod_near_reg;
        term_far_next   = term_far_reg;
        term_near_next  = term_near_reg;
        y_next          = y_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_dac_next      = m_dac_reg;

        mem_we       = 1'b0;
        mem_waddr    = ring_index_reg;
        mem_wdata    = y_reg;
        mem_raddr    = idx_far;

        div_start    = 1'b0;
        div_dividend = DIV_W'(sample_rate_reg);
        div_divisor  = s_note_freq;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (cmd_t'(s_cmd))
                        CMD_START: begin
                            ring_index_next = '0;
                            load_ptr_next   = '0;
                            elapsed_next    = '0;
                            if (s_note_freq == '0) begin
                                ring_order_next = ORD_W'(MAX_ORDER);
                                playing_next    = 1'b1;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_ORDER;
                            end
                        end
                        CMD_LOAD: begin
                            mem_we        = 1'b1;
                            mem_waddr     = load_ptr_reg;
                            mem_wdata     = noise_sat;
                            load_ptr_next = load_ptr_adv;
                        end
                        CMD_TICK: begin
                            if (playing_reg) begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc > ELAPSED_W'(timeout_reg)) begin
                                    playing_next = 1'b0;
                                end else begin
                                    // read of the far entry issued now
                                    idx_near_next = idx_near;
                                    state_next    = ST_FAR_MUL;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ORDER: begin
                if (div_done) begin
                    ring_order_next = order_clamped;
                    playing_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FAR_MUL: begin
                prod_far_next = coeff_far_reg * mem_rdata_reg;
                mem_raddr     = idx_near_reg;
                state_next    = ST_NEAR_MUL;
            end
            ST_NEAR_MUL: begin
                prod_near_next = coeff_near_reg * mem_rdata_reg;
                state_next     = ST_FAR_SCALE;
            end
            ST_FAR_SCALE: begin
                term_far_next = scale_term;
                state_next    = ST_NEAR_SCALE;
            end
            ST_NEAR_SCALE: begin
                term_near_next = scale_term;
                state_next     = ST_MIX;
            end
            ST_MIX: begin
                y_next     = mix_sat;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    mem_we          = 1'b1;
                    m_valid_next    = 1'b1;
                    m_dac_next      = dac_full[DAC_W-1:0];
                    ring_index_next = idx_far;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ring_index_reg <= '0;
            ring_order_reg <= '0;
            load_ptr_reg   <= '0;
            playing_reg    <= 1'b0;
            elapsed_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ring_index_reg <= ring_index_next;
            ring_order_reg <= ring_order_next;
            load_ptr_reg   <= load_ptr_next;
            playing_reg    <= playing_next;
            elapsed_reg    <= elapsed_next;
            m_valid_reg    <= m_valid_next;
        end
        idx_near_reg  <= idx_near_next;
        prod_far_reg  <= prod_far_next;
        prod_near_reg <= prod_near_next;
        term_far_reg  <= term_far_next;
        term_near_reg <= term_near_next;
        y_reg         <= y_next;
        m_dac_reg     <= m_dac_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_dac_code = m_dac_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_index_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_index_reg <= ring_order_reg)
        else $error("ring index beyond ring order");

    a_load_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        load_ptr_reg <= ring_order_reg)
        else $error("load pointer beyond ring order");

    a_order_when_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |-> (ring_order_reg >= ORD_W'(2)) &&
                        (ring_order_reg <= ORD_W'(MAX_ORDER)))
        else $error("playing with an order out of range");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_ORDER))
        else $error("divider finished outside the order step");

    a_writeback_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) && out_free |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("write-back did not present a result");

endmodule

### hw/rtl/plk_div.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module plk_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = (DVD_W > 2) ? $clog2(DVD_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;   // dividend shifts out, quotient shifts in
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath, no reset
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### test/testbench.sv
// Self-checking testbench for the plucked string synthesizer top level.
`timescale 1ns / 1ps

module testbench
    import plk_pkg::*;
;

    localparam int MAX_ORDER   = 511;
    localparam int IDX_W       = 9;
    // code 3 has no command behind it; the block must swallow it
    localparam logic [CMD_W-1:0] CMD_STRAY = 2'd3;

    // the voice mirror is kept twice: one copy runs ahead while stimulus is
    // planned, the other follows the transactions the block actually accepts
    localparam int AHEAD = 0;
    localparam int LIVE  = 1;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 206;
    localparam int SETTLE      = 80;        // at least the longest busy stretch without a result
    localparam int HOLD_AT     = 100;       // result count that starts the long hold
    localparam int LONG_HOLD   = 3000;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [NOTE_W-1:0]  note;
        logic [NOISE_W-1:0] noise;
    } voice_cmd_t;

    logic                      aclk;
    logic                      aresetn        = 1'b0;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_wr_index   = REG_SAMPLE_RATE;
    logic [CFG_DATA_W-1:0]     cfg_wr_data    = '0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_cmd          = CMD_START;
    logic [NOTE_W-1:0]         s_note_freq    = '0;
    logic signed [NOISE_W-1:0] s_noise_sample = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [DAC_W-1:0]          m_dac_code;

    plucked_string_synth #(
        .MAX_ORDER   (MAX_ORDER),
        .SAMPLE_BITS (12)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_note_freq    (s_note_freq),
        .s_noise_sample (s_noise_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dac_code     (m_dac_code)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Register shadows. Writes only happen while the block is idle, so both
    // mirror copies can share one set.
    logic [RATE_W-1:0]         rate_cfg   = SAMPLE_RATE_RST;
    logic signed [COEFF_W-1:0] gain_near  = COEFF_NEAR_RST;
    logic signed [COEFF_W-1:0] gain_far   = COEFF_FAR_RST;
    logic [TIMEOUT_W-1:0]      tick_limit = TIMEOUT_RST;

    // Voice mirror state, indexed by copy
    logic signed [NOISE_W-1:0] ring_mem [0:1][0:MAX_ORDER];
    bit                        ahead_loaded [0:MAX_ORDER];
    bit [IDX_W-1:0]            ring_idx [0:1];
    bit [IDX_W-1:0]            ring_ord [0:1];
    bit [IDX_W-1:0]            load_ptr [0:1];
    bit                        playing  [0:1];
    bit [ELAPSED_W-1:0]        elapsed  [0:1];

    voice_cmd_t       cmd_backlog [$];
    logic [DAC_W-1:0] dac_expected [$];

    int cmds_issued   = 0;
    int cmds_accepted = 0;
    int useful_cmds   = 0;     // transactions that are not simply swallowed
    int results_seen  = 0;
    int mismatches    = 0;
    int tx_gap = 0, tx_calm = 0;
    int rx_stall = 0, rx_calm = 0;
    int cycles_run = 0;

    // One command applied to one mirror copy; returns the DAC code of a
    // playing tick.
    function automatic void pluck_step(input int k, input logic [CMD_W-1:0] cmd,
                                       input logic [NOTE_W-1:0] note,
                                       input logic signed [NOISE_W-1:0] noise,
                                       output bit emits, output logic [DAC_W-1:0] code);
        int unsigned span, ord, at1, at2;
        int g_far, g_near, s1, s2, mixed, offs;
        emits = 1'b0;
        code  = '0;
        span  = int'(ring_ord[k]) + 1;
        case (cmd)
            CMD_START: begin
                if (note == 0)
                    ord = MAX_ORDER;
                else
                    ord = rate_cfg / note;
                if (ord < 2)
                    ord = 2;
                if (ord > MAX_ORDER)
                    ord = MAX_ORDER;
                ring_ord[k] = IDX_W'(ord);
                ring_idx[k] = '0;
                load_ptr[k] = '0;
                elapsed[k]  = '0;
                playing[k]  = 1'b1;
            end
            CMD_LOAD: begin
                ring_mem[k][load_ptr[k]] = noise;
                if (k == AHEAD)
                    ahead_loaded[load_ptr[k]] = 1'b1;
                // before the first start the ring is one entry long
                load_ptr[k] = IDX_W'((int'(load_ptr[k]) + 1) % span);
            end
            CMD_TICK: begin
                if (playing[k]) begin
                    if (elapsed[k] != ELAPSED_MAX)
                        elapsed[k] = elapsed[k] + 1'b1;
                    if (elapsed[k] > tick_limit) begin
                        playing[k] = 1'b0;
                    end else begin
                        at1    = (int'(ring_idx[k]) + 1) % span;
                        at2    = (int'(ring_idx[k]) + 2) % span;
                        g_far  = gain_far;
                        g_near = gain_near;
                        s1     = ring_mem[k][at1];
                        s2     = ring_mem[k][at2];
                        // each term truncates toward zero on its own
                        mixed  = (g_near * s2) / 1000 + (g_far * s1) / 1000;
                        if (mixed > 2047)
                            mixed = 2047;
                        if (mixed < -2048)
                            mixed = -2048;
                        ring_mem[k][ring_idx[k]] = NOISE_W'(mixed);
                        if (k == AHEAD)
                            ahead_loaded[ring_idx[k]] = 1'b1;
                        ring_idx[k] = IDX_W'((int'(ring_idx[k]) + 1) % span);
                        offs  = mixed + 2048;
                        code  = offs[DAC_W-1:0];
                        emits = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void push_item(input logic [CMD_W-1:0] cmd,
                                      input logic [NOTE_W-1:0] note,
                                      input logic [NOISE_W-1:0] noise);
        voice_cmd_t item;
        bit emits;
        logic [DAC_W-1:0] code;
        item.cmd   = cmd;
        item.note  = note;
        item.noise = noise;
        pluck_step(AHEAD, cmd, note, noise, emits, code);
        cmd_backlog.push_back(item);
        cmds_issued++;
        if (cmd == CMD_START || cmd == CMD_LOAD || emits)
            useful_cmds++;
    endfunction

    // A tick is only sent when it cannot read a delay-line entry that was never
    // written; a tick that times out or finds the voice silent reads nothing.
    function automatic void push_tick();
        int unsigned span, at1, at2;
        span = int'(ring_ord[AHEAD]) + 1;
        at1  = (int'(ring_idx[AHEAD]) + 1) % span;
        at2  = (int'(ring_idx[AHEAD]) + 2) % span;
        if (!playing[AHEAD] || elapsed[AHEAD] >= tick_limit ||
            (ahead_loaded[at1] && ahead_loaded[at2]))
            push_item(CMD_TICK, NOTE_W'($urandom), NOISE_W'($urandom));
    endfunction

    function automatic logic [NOISE_W-1:0] pick_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 12'h800;
        if (r < 20)
            return 12'h7FF;
        return NOISE_W'($urandom_range(0, 4095));
    endfunction

    // Idle stretch length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    // One note: start, fill the ring, then ticks with the odd load or stray code.
    // An untidy note may fill only part of the ring.
    function automatic void pluck_note(input bit tidy);
        int target, q, fill, r;
        logic [NOTE_W-1:0] note;
        target = $urandom_range(2, 40);
        if ($urandom_range(0, 19) == 0 || rate_cfg < 2) begin
            note = NOTE_W'($urandom_range(1, 65535));
        end else begin
            q = rate_cfg / target;
            if (q > 65535)
                q = 65535;
            if (q < 1)
                q = 1;
            note = NOTE_W'(q);
        end
        push_item(CMD_START, note, NOISE_W'($urandom));
        fill = int'(ring_ord[AHEAD]) + 1;
        if (!tidy)
            fill = $urandom_range(0, fill);
        repeat (fill) push_item(CMD_LOAD, NOTE_W'($urandom), pick_noise());
        repeat ($urandom_range(1, 45)) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                push_item(CMD_LOAD, NOTE_W'($urandom), pick_noise());
            else if (r < 5)
                push_item(CMD_STRAY, NOTE_W'($urandom), NOISE_W'($urandom));
            else
                push_tick();
        end
    endfunction

    // Short burst of arbitrary commands with arbitrary fields
    function automatic void scramble();
        logic [CMD_W-1:0] cmd;
        repeat ($urandom_range(1, 6)) begin
            cmd = CMD_W'($urandom_range(0, 3));
            if (cmd == CMD_TICK)
                push_tick();
            else
                push_item(cmd, NOTE_W'($urandom), NOISE_W'($urandom));
        end
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        case (idx)
            REG_SAMPLE_RATE: rate_cfg   = val[RATE_W-1:0];
            REG_COEFF_NEAR:  gain_near  = val[COEFF_W-1:0];
            REG_COEFF_FAR:   gain_far   = val[COEFF_W-1:0];
            REG_TIMEOUT:     tick_limit = val[TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_voice(input int rate, input int near, input int far, input int limit);
        write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(rate[RATE_W-1:0]));
        write_reg(REG_COEFF_NEAR, CFG_DATA_W'(near[COEFF_W-1:0]));
        write_reg(REG_COEFF_FAR, CFG_DATA_W'(far[COEFF_W-1:0]));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(limit[TIMEOUT_W-1:0]));
    endtask

    // Holds the sender until every transaction is taken and every result is
    // back, then lets a start still in flight finish.
    task automatic wait_idle();
        while (cmds_accepted != cmds_issued || dac_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Command driver: pops the backlog, holds each transaction until taken, and
    // predicts the result of each accepted one on the live mirror.
    always @(posedge aclk) begin : command_driver
        voice_cmd_t nxt;
        bit emits;
        logic [DAC_W-1:0] code;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pluck_step(LIVE, s_cmd, s_note_freq, s_noise_sample, emits, code);
                if (emits)
                    dac_expected.push_back(code);
                cmds_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    nxt = cmd_backlog.pop_front();
                    s_valid        <= 1'b1;
                    s_cmd          <= nxt.cmd;
                    s_note_freq    <= nxt.note;
                    s_noise_sample <= nxt.noise;
                    // gap that follows this transaction
                    if (tx_calm > 0) begin
                        tx_calm--;
                        tx_gap = 0;
                    end else begin
                        if ($urandom_range(0, 199) == 0)
                            tx_calm = 50;
                        tx_gap = ($urandom_range(0, 99) < 40) ? idle_len() : 0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken sample with the oldest prediction and
    // throttles m_ready, with one long hold to back the block up.
    always @(posedge aclk) begin : result_monitor
        logic [DAC_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (dac_expected.size() == 0) begin
                    $display("%0t: dac_code expected none, got %0d", $time, m_dac_code);
                    mismatches++;
                end else begin
                    want = dac_expected.pop_front();
                    if (m_dac_code !== want) begin
                        $display("%0t: dac_code expected %0d, got %0d",
                                 $time, want, m_dac_code);
                        mismatches++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                    rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (rx_calm > 0)
                    rx_calm--;
                else if ($urandom_range(0, 299) == 0)
                    rx_calm = 200;
                else if ($urandom_range(0, 99) < 12)
                    rx_stall = idle_len();
            end
        end
    end

    initial begin : watchdog
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        int phase, goal, r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings (rate 100000, gains 500)
        push_tick();                                 // silent voice: swallowed
        push_item(CMD_STRAY, 16'hFFFF, 12'hFFF);     // stray code: swallowed
        push_item(CMD_LOAD, 16'h0000, 12'h800);      // load before any start hits entry 0
        push_item(CMD_LOAD, 16'hFFFF, 12'h7FF);      // ... and stays there
        push_item(CMD_START, 16'hFFFF, 12'h000);     // quotient 1 clamps to order 2
        push_item(CMD_LOAD, 16'h0000, 12'h800);
        push_item(CMD_LOAD, 16'h0000, 12'h7FF);
        push_item(CMD_LOAD, 16'h0000, 12'h555);
        repeat (6) push_tick();                      // index wraps over the 3-entry ring
        push_item(CMD_STRAY, 16'h0000, 12'h000);
        push_item(CMD_START, 16'h0000, 12'hAAA);     // note 0: longest ring, restart
        push_tick();
        push_item(CMD_START, 16'd50000, 12'h000);    // back to order 2 while playing
        push_item(CMD_LOAD, 16'h1234, 12'hFFF);      // load while playing
        repeat (3) push_tick();
        push_item(CMD_START, 16'd1, 12'h000);        // huge quotient clamps to the top
        wait_idle();

        goal = useful_cmds;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_voice(100000, 2000, 2000, 1048575);   // saturating gains
                1: set_voice(200000, -2000, -2000, 60);
                2: set_voice(1, 0, 2000, 30);
                3: set_voice(0, 1000, -1000, 1);              // one sample per note
                4: set_voice(100000, -2000, 2000, 25);
                default: set_voice($urandom_range(1000, 200000),
                                   int'($urandom_range(0, 4000)) - 2000,
                                   int'($urandom_range(0, 4000)) - 2000,
                                   $urandom_range(1, 80));
            endcase
            if (phase == 2) begin
                // note 0 with the whole ring loaded, run past the timeout
                push_item(CMD_START, 16'h0000, NOISE_W'($urandom));
                repeat (MAX_ORDER + 1) push_item(CMD_LOAD, NOTE_W'($urandom), pick_noise());
                repeat (40) push_tick();
            end
            goal += PHASE_ITEMS;
            while (useful_cmds < goal) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    pluck_note(1'b1);
                else if (r < 90)
                    pluck_note(1'b0);
                else
                    scramble();
            end
            wait_idle();
        end

        if (mismatches == 0 && dac_expected.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
